// File: rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Width of one stored value.
    localparam int unsigned DATA_W = 32;

    // Default number of slots in the ring buffer.
    localparam int unsigned DEPTH_DEFAULT = 1024;

    // Value reported where no value exists.
    localparam logic signed [DATA_W-1:0] NONE_VALUE = '1;

    // Item kinds; the unused codes behave as a query.
    typedef enum logic [2:0] {
        KIND_QUERY      = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_PUSH_BACK  = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_POP_BACK   = 3'd4
    } t_kind;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIN  = 2'b10
    } t_state;

endpackage

`default_nettype wire

// File: rtl/double_ended_queue_core.sv
`default_nettype none

// An accepted transaction waits in the finishing state and writes its result to the output
// register as it leaves, which it does only while that register is free; only then is a new
// transaction taken. A pop's single slot memory read fetches the new front or back value.
// Reset (synchronous, active low) empties the queue and clears the output valid bit; the
// slot memory is not cleared; no clearing pass is needed: unwritten data is never reported.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    localparam int unsigned AW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Input channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [2:0]               i_kind,
    input  wire logic signed [DATA_W-1:0] i_value,
    // Output channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_popped_value,
    output logic [CW-1:0]                 o_entry_count,
    output logic                          o_is_empty,
    output logic signed [DATA_W-1:0]      o_front_value,
    output logic signed [DATA_W-1:0]      o_back_value,
    output logic                          o_push_dropped
);

    // Wraps a sum of two in-range offsets back into the ring. The sum is always below
    // twice the depth, so a single compare and subtract is enough.
    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] sum);
        logic [AW:0] reduced;
        begin
            reduced = sum - (AW+1)'(DEPTH);
            if (sum >= (AW+1)'(DEPTH)) begin
                return reduced[AW-1:0];
            end
            return sum[AW-1:0];
        end
    endfunction

    // Sequencer and the accepted transaction.
    t_state                    r_state;
    t_state                    n_state;
    logic [2:0]                r_kind;
    logic signed [DATA_W-1:0]  r_value;

    // Queue state. The end values are held in registers so that every result can report
    // them; the memory is only read to refill an end after a pop.
    logic [AW-1:0]             r_front_pos;
    logic [AW-1:0]             n_front_pos;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic signed [DATA_W-1:0]  r_front_val;
    logic signed [DATA_W-1:0]  n_front_val;
    logic signed [DATA_W-1:0]  r_back_val;
    logic signed [DATA_W-1:0]  n_back_val;

    // Output register.
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_popped;
    logic [CW-1:0]             r_out_count;
    logic                      r_out_empty;
    logic signed [DATA_W-1:0]  r_out_front;
    logic signed [DATA_W-1:0]  r_out_back;
    logic                      r_out_dropped;

    // Memory port signals.
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [DATA_W-1:0]         rd_data;
    logic                      wr_req;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;

    // Working values for the finishing cycle.
    logic                      in_acc;
    logic                      fin_go;
    logic                      q_empty;
    logic                      q_full;
    logic [AW-1:0]             pos_dec;
    logic [AW-1:0]             pos_inc;
    logic [AW-1:0]             pos_tail;
    logic [AW-1:0]             pos_new_back;
    logic signed [DATA_W-1:0]  popped;
    logic                      dropped;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // The result may leave the finishing state whenever the output register is free at
    // this edge, so a new transaction is taken while an earlier result still waits.
    assign fin_go = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign q_empty = (r_count == '0);
    assign q_full  = (r_count == CW'(DEPTH));

    // Slot positions relative to the current front.
    assign pos_dec      = (r_front_pos == '0) ? AW'(DEPTH - 1) : (r_front_pos - AW'(1));
    assign pos_inc      = f_wrap({1'b0, r_front_pos} + (AW+1)'(1));
    assign pos_tail     = f_wrap({1'b0, r_front_pos} + (AW+1)'(r_count));
    assign pos_new_back = f_wrap({1'b0, r_front_pos} + (AW+1)'(r_count) - (AW+1)'(2));

    // A pop reads the slot that becomes the new end. The state does not change between
    // acceptance and the finishing cycle, so the address is formed from the live state.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = pos_inc;
        case (i_kind)
            KIND_POP_FRONT: begin
                rd_en   = in_acc;
                rd_addr = pos_inc;
            end
            KIND_POP_BACK: begin
                rd_en   = in_acc;
                rd_addr = pos_new_back;
            end
            default: begin
            end
        endcase
    end

    // Next queue state and the result of the transaction in the finishing cycle.
    always_comb begin
        n_front_pos = r_front_pos;
        n_count     = r_count;
        n_front_val = r_front_val;
        n_back_val  = r_back_val;
        popped      = NONE_VALUE;
        dropped     = 1'b0;
        wr_req      = 1'b0;
        wr_addr     = pos_tail;
        case (r_kind) inside
            KIND_PUSH_FRONT: begin
                if (q_full) begin
                    dropped = 1'b1;
                end else begin
                    wr_req      = 1'b1;
                    wr_addr     = pos_dec;
                    n_front_pos = pos_dec;
                    n_count     = r_count + CW'(1);
                    n_front_val = r_value;
                    if (q_empty) begin
                        n_back_val = r_value;
                    end
                end
            end
            KIND_PUSH_BACK: begin
                if (q_full) begin
                    dropped = 1'b1;
                end else begin
                    wr_req     = 1'b1;
                    wr_addr    = pos_tail;
                    n_count    = r_count + CW'(1);
                    n_back_val = r_value;
                    if (q_empty) begin
                        n_front_val = r_value;
                    end
                end
            end
            KIND_POP_FRONT: begin
                if (!q_empty) begin
                    popped      = r_front_val;
                    n_front_pos = pos_inc;
                    n_count     = r_count - CW'(1);
                    n_front_val = $signed(rd_data);
                end
            end
            KIND_POP_BACK: begin
                if (!q_empty) begin
                    popped     = r_back_val;
                    n_count    = r_count - CW'(1);
                    n_back_val = $signed(rd_data);
                end
            end
            default: begin
            end
        endcase
    end

    assign wr_en = fin_go && wr_req;

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = in_acc ? S_FIN : S_IDLE;
            S_FIN:   n_state = fin_go ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front_pos <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_front_pos <= n_front_pos;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (fin_go) begin
            r_front_val   <= n_front_val;
            r_back_val    <= n_back_val;
            r_popped      <= popped;
            r_out_count   <= n_count;
            r_out_empty   <= (n_count == '0);
            r_out_front   <= (n_count == '0) ? NONE_VALUE : n_front_val;
            r_out_back    <= (n_count == '0) ? NONE_VALUE : n_back_val;
            r_out_dropped <= dropped;
        end
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_entry_count  = r_out_count;
    assign o_is_empty     = r_out_empty;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_push_dropped = r_out_dropped;

endmodule

`default_nettype wire

// File: rtl/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read data holds its value until the next read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
